[sv/per_client_dual_token_bucket_policer_core_assert.svh]
// Assertion macros shared by the policer RTL
`ifndef PER_CLIENT_DUAL_TOKEN_BUCKET_POLICER_CORE_ASSERT_SVH
`define PER_CLIENT_DUAL_TOKEN_BUCKET_POLICER_CORE_ASSERT_SVH

// same-cycle implication
`define PCDTB_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("policer assertion failed");

// next-cycle implication
`define PCDTB_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("policer assertion failed");

`endif

[sv/pcdtb_pkg.sv]
// Types, codes and defaults for the dual token bucket policer
`default_nettype none
package pcdtb_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_LOAD,
    ST_MULP,
    ST_FILLP,
    ST_MULB,
    ST_FILLB,
    ST_DECAY,
    ST_DCMP,
    ST_DIV,
    ST_CHECK,
    ST_FIN,
    ST_OUT
  } state_t;

  localparam logic [1:0] OP_ALLOW   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;
  localparam logic [1:0] OP_PEEK    = 2'd3;

  localparam logic [2:0] CFG_PACKET_RATE  = 3'd0;
  localparam logic [2:0] CFG_BYTE_RATE    = 3'd1;
  localparam logic [2:0] CFG_PACKET_BURST = 3'd2;
  localparam logic [2:0] CFG_BYTE_BURST   = 3'd3;
  localparam logic [2:0] CFG_DECAY_IV     = 3'd4;
  localparam logic [2:0] CFG_VIOL_LIMIT   = 3'd5;
  localparam logic [2:0] CFG_QUAR_LEN     = 3'd6;

  localparam int DEF_NUM_CLIENTS = 64;
  localparam int DEF_FRAC_BITS   = 16;
  localparam int DEF_TIME_WIDTH  = 48;

  localparam logic [31:0] RST_PACKET_RATE  = 32'd65536;
  localparam logic [31:0] RST_BYTE_RATE    = 32'd65536;
  localparam logic [15:0] RST_PACKET_BURST = 16'd64;
  localparam logic [31:0] RST_BYTE_BURST   = 32'd65536;
  localparam logic [31:0] RST_DECAY_IV     = 32'd1000000;
  localparam logic [15:0] RST_VIOL_LIMIT   = 16'd10;
  localparam logic [31:0] RST_QUAR_LEN     = 32'd5000000;

  localparam int DIV_STEPS = 16;

endpackage
`default_nettype wire

[sv/per_client_dual_token_bucket_policer_core.sv]
// Per-client dual token bucket policer, top level
// Usage:
//   Input channel (in_valid/in_stall) carries one item: opcode, client slot,
//   packet size and the current tick count. Opcodes: allow, release slot,
//   clear violations, peek. The result channel (out_valid/out_stall) returns one
//   item per input: pass flag, quarantine flag, violations and whole tokens
//   left in both buckets.
//   One item is worked at a time; in_stall is high from acceptance until the
//   result has been taken. An allow item may run two chunked 16x32 multiplies
//   for the refills (NCH = 16-bit tick chunks, 3 at 48 bits), one multiply for
//   the decay bound, and a 16-step restoring divide for the decay count. Other
//   opcodes and out-of-range slots skip the arithmetic and go from the slot
//   read straight to the result.
//   Slot state lives in one RAM with registered read; a valid flop per slot
//   marks slots used since reset or release.
//   Reset (synchronous, rst_n low) clears all slots to unused and restores
//   the register defaults; no clearing pass is needed.
//   While out_stall is high the result holds and no new item is taken.
//   Registers are written through cfg_we/cfg_index/cfg_wdata by the user, only while idle; the block has no check.
`default_nettype none
`include "per_client_dual_token_bucket_policer_core_assert.svh"
module per_client_dual_token_bucket_policer_core #(
  parameter int NUM_CLIENTS = pcdtb_pkg::DEF_NUM_CLIENTS,
  parameter int FRAC_BITS   = pcdtb_pkg::DEF_FRAC_BITS,
  parameter int TIME_WIDTH  = pcdtb_pkg::DEF_TIME_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [31:0]           cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_opcode,
  input  wire logic [5:0]            in_client_slot,
  input  wire logic [15:0]           in_packet_bytes,
  input  wire logic [TIME_WIDTH-1:0] in_now_ticks,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_allowed,
  output logic                       out_quarantined,
  output logic [15:0]                out_violation_count,
  output logic [15:0]                out_packet_tokens_left,
  output logic [31:0]                out_byte_tokens_left
);

  localparam int SW  = NUM_CLIENTS > 1 ? $clog2(NUM_CLIENTS) : 1;
  localparam int PTW = 16 + FRAC_BITS;
  localparam int BTW = 32 + FRAC_BITS;
  localparam int TW  = TIME_WIDTH;
  localparam int NCH = (TW + 15) / 16;
  localparam int ESW = NCH * 16;
  localparam int PW  = TW + 32;
  localparam int DW  = TW > 48 ? TW : 48;
  localparam int WW  = PTW + BTW + 3 * TW + 17;

  pcdtb_pkg::state_t state_r, state_nxt;

  logic [31:0] prate_r, brate_r, bburst_r, div_r, qlen_r;
  logic [15:0] pburst_r, vlimit_r;
  logic [NUM_CLIENTS-1:0] valid_r;

  logic [1:0]     op_r;
  logic [SW-1:0]  slot_r;
  logic           inrange_r;
  logic [15:0]    bytes_r;
  logic [TW-1:0]  now_r;

  logic [PTW-1:0] pt_r, pt_nxt;
  logic [BTW-1:0] bt_r, bt_nxt;
  logic [TW-1:0]  lrt_r, lrt_nxt, ldt_r, ldt_nxt, qend_r, qend_nxt;
  logic [15:0]    v_r, v_nxt;
  logic           inq_r, inq_nxt;
  logic [PW-1:0]  acc_r, acc_nxt;
  logic [47:0]    mul_r, mul_nxt;
  logic [ESW-1:0] el_sh_r, el_sh_nxt;
  logic [TW-1:0]  el_r, el_nxt;
  logic [4:0]     cnt_r, cnt_nxt;
  logic [15:0]    q_r, q_nxt;
  logic [DW-1:0]  rem_r, rem_nxt, dv_r, dv_nxt;
  logic           allowed_r, allowed_nxt, zero_r, zero_nxt;
  logic           wr_r, wr_nxt, rel_r, rel_nxt;

  logic [WW-1:0]  ram_rdata, ram_wdata;
  logic [SW-1:0]  ram_raddr;
  logic           ram_we;

  logic [PTW-1:0] rd_pt, base_pt, ld_pt, pcap, one_tok, p_room, p_fill;
  logic [BTW-1:0] rd_bt, base_bt, ld_bt, bcap, need, b_room, b_fill;
  logic [TW-1:0]  rd_lrt, rd_ldt, rd_qend, base_lrt, base_ldt, base_qend, ld_lrt;
  logic [15:0]    rd_v, base_v, v_inc, q_step;
  logic           rd_inq, base_inq, slot_vld, quar_hold, qexit, div_ge, reject;
  logic [31:0]    iv;
  logic [TW-1:0]  el2;
  logic [TW:0]    qsum;
  logic [TW-1:0]  qend_sat;
  logic [15:0]    mul_a;
  logic [31:0]    mul_b;

  pcdtb_ram #(
    .WIDTH(WW),
    .DEPTH(NUM_CLIENTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot_r),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign ram_raddr = (state_r == pcdtb_pkg::ST_IDLE) ? SW'(in_client_slot) : slot_r;
  assign ram_we    = (state_r == pcdtb_pkg::ST_FIN) && wr_r;
  assign ram_wdata = {pt_r, bt_r, lrt_r, ldt_r, v_r, inq_r, qend_r};
  assign {rd_pt, rd_bt, rd_lrt, rd_ldt, rd_v, rd_inq, rd_qend} = ram_rdata;

  assign pcap    = PTW'(pburst_r) << FRAC_BITS;
  assign bcap    = BTW'(bburst_r) << FRAC_BITS;
  assign need    = BTW'(bytes_r) << FRAC_BITS;
  assign one_tok = PTW'(1) << FRAC_BITS;
  assign iv      = (div_r == 32'd0) ? 32'd1 : div_r;
  assign slot_vld = valid_r[slot_r];

  assign base_pt   = slot_vld ? rd_pt   : pcap;
  assign base_bt   = slot_vld ? rd_bt   : bcap;
  assign base_lrt  = slot_vld ? rd_lrt  : now_r;
  assign base_ldt  = slot_vld ? rd_ldt  : now_r;
  assign base_v    = slot_vld ? rd_v    : 16'd0;
  assign base_inq  = slot_vld ? rd_inq  : 1'b0;
  assign base_qend = slot_vld ? rd_qend : '0;
  assign quar_hold = base_inq && (now_r < base_qend);
  assign qexit     = base_inq && !(now_r < base_qend);
  assign ld_pt     = qexit ? (pcap >> 1) : base_pt;
  assign ld_bt     = qexit ? (bcap >> 1) : base_bt;
  assign ld_lrt    = qexit ? now_r : base_lrt;

  assign p_room = pcap - pt_r;
  assign p_fill = (pt_r >= pcap) ? pcap :
                  (acc_r > PW'(p_room)) ? pcap : pt_r + PTW'(acc_r);
  assign b_room = bcap - bt_r;
  assign b_fill = (bt_r >= bcap) ? bcap :
                  (acc_r > PW'(b_room)) ? bcap : bt_r + BTW'(acc_r);

  assign el2    = now_r - ldt_r;
  assign div_ge = rem_r >= dv_r;
  assign q_step = {q_r[14:0], div_ge};
  assign reject = (pt_r < one_tok) || (bt_r < need);
  assign v_inc  = (v_r == 16'hFFFF) ? v_r : v_r + 16'd1;
  assign qsum   = (TW+1)'(now_r) + (TW+1)'(qlen_r);
  assign qend_sat = qsum[TW] ? '1 : qsum[TW-1:0];

  always_comb begin
    mul_a = 16'd0;
    mul_b = 32'd0;
    case (state_r)
      pcdtb_pkg::ST_MULP: begin
        mul_a = el_sh_r[ESW-1 -: 16];
        mul_b = prate_r;
      end
      pcdtb_pkg::ST_MULB: begin
        mul_a = el_sh_r[ESW-1 -: 16];
        mul_b = brate_r;
      end
      pcdtb_pkg::ST_DECAY: begin
        mul_a = v_r;
        mul_b = iv;
      end
      default: begin
      end
    endcase
    mul_nxt = 48'(mul_a) * 48'(mul_b);
  end

  always_comb begin
    state_nxt   = state_r;
    pt_nxt      = pt_r;
    bt_nxt      = bt_r;
    lrt_nxt     = lrt_r;
    ldt_nxt     = ldt_r;
    v_nxt       = v_r;
    inq_nxt     = inq_r;
    qend_nxt    = qend_r;
    acc_nxt     = acc_r;
    el_sh_nxt   = el_sh_r;
    el_nxt      = el_r;
    cnt_nxt     = cnt_r;
    q_nxt       = q_r;
    rem_nxt     = rem_r;
    dv_nxt      = dv_r;
    allowed_nxt = allowed_r;
    zero_nxt    = zero_r;
    wr_nxt      = wr_r;
    rel_nxt     = rel_r;
    case (state_r)
      pcdtb_pkg::ST_IDLE: begin
        allowed_nxt = 1'b0;
        zero_nxt    = 1'b0;
        wr_nxt      = 1'b0;
        rel_nxt     = 1'b0;
        if (in_valid) begin
          state_nxt = pcdtb_pkg::ST_RD;
        end
      end
      pcdtb_pkg::ST_RD: begin
        state_nxt = pcdtb_pkg::ST_LOAD;
      end
      pcdtb_pkg::ST_LOAD: begin
        state_nxt = pcdtb_pkg::ST_FIN;
        pt_nxt    = rd_pt;
        bt_nxt    = rd_bt;
        lrt_nxt   = rd_lrt;
        ldt_nxt   = rd_ldt;
        v_nxt     = rd_v;
        inq_nxt   = rd_inq;
        qend_nxt  = rd_qend;
        if (!inrange_r) begin
          zero_nxt = 1'b1;
        end else begin
          case (op_r)
            pcdtb_pkg::OP_RELEASE: begin
              zero_nxt = 1'b1;
              rel_nxt  = 1'b1;
            end
            pcdtb_pkg::OP_CLEAR: begin
              if (!slot_vld) begin
                zero_nxt = 1'b1;
              end else begin
                v_nxt   = 16'd0;
                inq_nxt = 1'b0;
                ldt_nxt = now_r;
                wr_nxt  = 1'b1;
              end
            end
            pcdtb_pkg::OP_ALLOW: begin
              wr_nxt   = 1'b1;
              pt_nxt   = ld_pt;
              bt_nxt   = ld_bt;
              lrt_nxt  = ld_lrt;
              ldt_nxt  = base_ldt;
              v_nxt    = base_v;
              inq_nxt  = base_inq && quar_hold;
              qend_nxt = base_qend;
              if (!quar_hold) begin
                if (now_r > ld_lrt) begin
                  el_nxt    = now_r - ld_lrt;
                  el_sh_nxt = ESW'(now_r - ld_lrt);
                  acc_nxt   = '0;
                  cnt_nxt   = 5'd0;
                  state_nxt = pcdtb_pkg::ST_MULP;
                end else begin
                  state_nxt = pcdtb_pkg::ST_DECAY;
                end
              end
            end
            default: begin
              zero_nxt = !slot_vld;
            end
          endcase
        end
      end
      pcdtb_pkg::ST_MULP, pcdtb_pkg::ST_MULB: begin
        el_sh_nxt = el_sh_r << 16;
        cnt_nxt   = cnt_r + 5'd1;
        if (cnt_r != 5'd0) begin
          acc_nxt = (acc_r << 16) + PW'(mul_r);
        end
        if (cnt_r == 5'(NCH)) begin
          state_nxt = (state_r == pcdtb_pkg::ST_MULP) ? pcdtb_pkg::ST_FILLP
                                                      : pcdtb_pkg::ST_FILLB;
        end
      end
      pcdtb_pkg::ST_FILLP: begin
        pt_nxt    = p_fill;
        el_sh_nxt = ESW'(el_r);
        acc_nxt   = '0;
        cnt_nxt   = 5'd0;
        state_nxt = pcdtb_pkg::ST_MULB;
      end
      pcdtb_pkg::ST_FILLB: begin
        bt_nxt    = b_fill;
        lrt_nxt   = now_r;
        state_nxt = pcdtb_pkg::ST_DECAY;
      end
      pcdtb_pkg::ST_DECAY: begin
        state_nxt = pcdtb_pkg::ST_CHECK;
        if (v_r == 16'd0) begin
          ldt_nxt = now_r;
        end else if (now_r >= ldt_r) begin
          if (DW'(el2) >= DW'(iv)) begin
            rem_nxt   = DW'(el2);
            state_nxt = pcdtb_pkg::ST_DCMP;
          end
        end
      end
      pcdtb_pkg::ST_DCMP: begin
        if (rem_r >= DW'(mul_r)) begin
          v_nxt     = 16'd0;
          ldt_nxt   = now_r;
          state_nxt = pcdtb_pkg::ST_CHECK;
        end else begin
          q_nxt     = 16'd0;
          cnt_nxt   = 5'd0;
          dv_nxt    = DW'(iv) << (pcdtb_pkg::DIV_STEPS - 1);
          state_nxt = pcdtb_pkg::ST_DIV;
        end
      end
      pcdtb_pkg::ST_DIV: begin
        q_nxt   = q_step;
        rem_nxt = div_ge ? rem_r - dv_r : rem_r;
        dv_nxt  = dv_r >> 1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(pcdtb_pkg::DIV_STEPS - 1)) begin
          v_nxt     = v_r - q_step;
          ldt_nxt   = now_r;
          state_nxt = pcdtb_pkg::ST_CHECK;
        end
      end
      pcdtb_pkg::ST_CHECK: begin
        state_nxt = pcdtb_pkg::ST_FIN;
        if (reject) begin
          v_nxt = v_inc;
          if (v_inc >= vlimit_r) begin
            inq_nxt  = 1'b1;
            qend_nxt = qend_sat;
          end
        end else begin
          pt_nxt      = pt_r - one_tok;
          bt_nxt      = bt_r - need;
          allowed_nxt = 1'b1;
        end
      end
      pcdtb_pkg::ST_FIN: begin
        state_nxt = pcdtb_pkg::ST_OUT;
      end
      pcdtb_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_nxt = pcdtb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pcdtb_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall  = state_r != pcdtb_pkg::ST_IDLE;
  assign out_valid = state_r == pcdtb_pkg::ST_OUT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pcdtb_pkg::ST_IDLE;
      valid_r  <= '0;
      prate_r  <= pcdtb_pkg::RST_PACKET_RATE;
      brate_r  <= pcdtb_pkg::RST_BYTE_RATE;
      pburst_r <= pcdtb_pkg::RST_PACKET_BURST;
      bburst_r <= pcdtb_pkg::RST_BYTE_BURST;
      div_r    <= pcdtb_pkg::RST_DECAY_IV;
      vlimit_r <= pcdtb_pkg::RST_VIOL_LIMIT;
      qlen_r   <= pcdtb_pkg::RST_QUAR_LEN;
    end else begin
      state_r <= state_nxt;
      if (state_r == pcdtb_pkg::ST_FIN) begin
        if (rel_r) begin
          valid_r[slot_r] <= 1'b0;
        end else if (wr_r && op_r == pcdtb_pkg::OP_ALLOW) begin
          valid_r[slot_r] <= 1'b1;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          pcdtb_pkg::CFG_PACKET_RATE:  prate_r  <= cfg_wdata;
          pcdtb_pkg::CFG_BYTE_RATE:    brate_r  <= cfg_wdata;
          pcdtb_pkg::CFG_PACKET_BURST: pburst_r <= cfg_wdata[15:0];
          pcdtb_pkg::CFG_BYTE_BURST:   bburst_r <= cfg_wdata;
          pcdtb_pkg::CFG_DECAY_IV:     div_r    <= cfg_wdata;
          pcdtb_pkg::CFG_VIOL_LIMIT:   vlimit_r <= cfg_wdata[15:0];
          pcdtb_pkg::CFG_QUAR_LEN:     qlen_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == pcdtb_pkg::ST_IDLE && in_valid) begin
      op_r      <= in_opcode;
      slot_r    <= SW'(in_client_slot);
      inrange_r <= 13'(in_client_slot) < 13'(NUM_CLIENTS);
      bytes_r   <= in_packet_bytes;
      now_r     <= in_now_ticks;
    end
    pt_r      <= pt_nxt;
    bt_r      <= bt_nxt;
    lrt_r     <= lrt_nxt;
    ldt_r     <= ldt_nxt;
    v_r       <= v_nxt;
    inq_r     <= inq_nxt;
    qend_r    <= qend_nxt;
    acc_r     <= acc_nxt;
    mul_r     <= mul_nxt;
    el_sh_r   <= el_sh_nxt;
    el_r      <= el_nxt;
    cnt_r     <= cnt_nxt;
    q_r       <= q_nxt;
    rem_r     <= rem_nxt;
    dv_r      <= dv_nxt;
    allowed_r <= allowed_nxt;
    zero_r    <= zero_nxt;
    wr_r      <= wr_nxt;
    rel_r     <= rel_nxt;
    if (state_r == pcdtb_pkg::ST_FIN) begin
      if (zero_r) begin
        out_allowed            <= 1'b0;
        out_quarantined        <= 1'b0;
        out_violation_count    <= 16'd0;
        out_packet_tokens_left <= 16'd0;
        out_byte_tokens_left   <= 32'd0;
      end else begin
        out_allowed            <= allowed_r;
        out_quarantined        <= inq_r && (now_r < qend_r);
        out_violation_count    <= v_r;
        out_packet_tokens_left <= 16'(pt_r >> FRAC_BITS);
        out_byte_tokens_left   <= 32'(bt_r >> FRAC_BITS);
      end
    end
  end

  `PCDTB_IMP(a_out_blocks_in, out_valid, in_stall)
  `PCDTB_NXT(a_accept_reads, in_valid && !in_stall, state_r == pcdtb_pkg::ST_RD)
  `PCDTB_NXT(a_fin_shows, state_r == pcdtb_pkg::ST_FIN, out_valid)
  `PCDTB_IMP(a_div_bound, state_r == pcdtb_pkg::ST_DIV, cnt_r < 5'd16)

endmodule
`default_nettype wire

[sv/pcdtb_ram.sv]
// Generic single-port-write, registered-read RAM
`default_nettype none
module pcdtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[tb/per_client_dual_token_bucket_policer_core_tb.sv]
// Testbench for the per-client dual token bucket policer: directed table plus random phases
`default_nettype none
module per_client_dual_token_bucket_policer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned TMAX = 64'hFFFF_FFFF_FFFF;
  localparam longint unsigned ONE_TOKEN = 64'h1_0000;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic        allowed;
    logic        quarantined;
    logic [15:0] violation_count;
    logic [15:0] packet_tokens_left;
    logic [31:0] byte_tokens_left;
  } verdict_t;

  typedef struct {
    logic [1:0]  op;
    logic [5:0]  slot;
    logic [15:0] bytes;
    logic [47:0] now;
    bit          typed;
    verdict_t    want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_opcode = '0;
  logic [5:0] in_client_slot = '0;
  logic [15:0] in_packet_bytes = '0;
  logic [47:0] in_now_ticks = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_allowed, out_quarantined;
  logic [15:0] out_violation_count, out_packet_tokens_left;
  logic [31:0] out_byte_tokens_left;

  bit row_typed = 1'b0;
  verdict_t row_want = '0;
  bit calm = 1'b0;

  per_client_dual_token_bucket_policer_core i_dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_opcode, .in_client_slot, .in_packet_bytes, .in_now_ticks,
    .out_valid, .out_stall, .out_allowed, .out_quarantined, .out_violation_count,
    .out_packet_tokens_left, .out_byte_tokens_left
  );

  always #5 clk = ~clk;

  // policer state as predicted
  longint unsigned pkt_rate, byt_rate, pkt_burst, byt_burst, decay_iv, viol_limit, quar_len;
  bit              used [64];
  longint unsigned pkt_tok [64];
  longint unsigned byt_tok [64];
  longint unsigned refill_at [64];
  longint unsigned decay_at [64];
  longint unsigned viol [64];
  bit              quar [64];
  longint unsigned quar_end [64];

  verdict_t pending_verdicts [$];
  int mismatches = 0;
  int items_in = 0, passes = 0, rejects = 0, quar_seen = 0;
  int stuck = 0;

  function automatic longint unsigned refill(longint unsigned tok, longint unsigned el,
                                             longint unsigned rate, longint unsigned cap);
    if (tok >= cap) return cap;
    if (rate == 0) return tok;
    if (el > (cap - tok) / rate) return cap;
    return tok + el * rate;
  endfunction

  function automatic verdict_t slot_view(int s, longint unsigned now);
    verdict_t v;
    v = '0;
    v.quarantined = quar[s] && now < quar_end[s];
    v.violation_count = viol[s][15:0];
    v.packet_tokens_left = pkt_tok[s][31:16];
    v.byte_tokens_left = byt_tok[s][47:16];
    return v;
  endfunction

  function automatic verdict_t police(logic [1:0] op, int s, longint unsigned bytes,
                                      longint unsigned now);
    longint unsigned pcap, bcap, need, el, iv, d, qe;
    verdict_t v;
    pcap = pkt_burst << 16;
    bcap = byt_burst << 16;
    need = bytes << 16;
    v = '0;
    case (op)
      pcdtb_pkg::OP_RELEASE: used[s] = 1'b0;
      pcdtb_pkg::OP_CLEAR: if (used[s]) begin
        viol[s] = 0;
        quar[s] = 1'b0;
        decay_at[s] = now;
        v = slot_view(s, now);
      end
      pcdtb_pkg::OP_PEEK: if (used[s]) v = slot_view(s, now);
      default: begin
        if (!used[s]) begin
          used[s] = 1'b1;
          pkt_tok[s] = pcap;
          byt_tok[s] = bcap;
          refill_at[s] = now;
          decay_at[s] = now;
          viol[s] = 0;
          quar[s] = 1'b0;
          quar_end[s] = 0;
        end
        if (quar[s] && now < quar_end[s]) return slot_view(s, now);
        if (quar[s]) begin
          quar[s] = 1'b0;
          pkt_tok[s] = pcap >> 1;
          byt_tok[s] = bcap >> 1;
          refill_at[s] = now;
        end
        if (now > refill_at[s]) begin
          el = now - refill_at[s];
          pkt_tok[s] = refill(pkt_tok[s], el, pkt_rate, pcap);
          byt_tok[s] = refill(byt_tok[s], el, byt_rate, bcap);
          refill_at[s] = now;
        end
        if (viol[s] == 0) begin
          decay_at[s] = now;
        end else if (now >= decay_at[s]) begin
          el = now - decay_at[s];
          iv = (decay_iv == 0) ? 1 : decay_iv;
          if (el >= iv) begin
            d = el / iv;
            viol[s] = (d >= viol[s]) ? 0 : viol[s] - d;
            decay_at[s] = now;
          end
        end
        if (pkt_tok[s] < ONE_TOKEN || byt_tok[s] < need) begin
          if (viol[s] < 65535) viol[s]++;
          if (viol[s] >= viol_limit) begin
            qe = now + quar_len;
            if (qe > TMAX) qe = TMAX;
            quar[s] = 1'b1;
            quar_end[s] = qe;
          end
          return slot_view(s, now);
        end
        pkt_tok[s] -= ONE_TOKEN;
        byt_tok[s] -= need;
        v = slot_view(s, now);
        v.allowed = 1'b1;
      end
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t got, want, model;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        model = police(in_opcode, int'(in_client_slot), 64'(in_packet_bytes),
                       64'(in_now_ticks));
        pending_verdicts.insert(pending_verdicts.size(), row_typed ? row_want : model);
        items_in++;
      end
      if (out_valid && !out_stall) begin
        got = {out_allowed, out_quarantined, out_violation_count,
               out_packet_tokens_left, out_byte_tokens_left};
        if (pending_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = pending_verdicts.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
        if (got.allowed) passes++; else rejects++;
        if (got.quarantined) quar_seen++;
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= !calm && $urandom_range(99) < 11;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
      if (stuck >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send(logic [1:0] op, logic [5:0] slot, logic [15:0] bytes, logic [47:0] now,
                      bit typed = 1'b0, verdict_t want = '0);
    if (!calm && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_client_slot <= slot;
    in_packet_bytes <= bytes;
    in_now_ticks <= now;
    row_typed <= typed;
    row_want <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_regs(longint unsigned vals [7]);
    logic [2:0] idx [7];
    idx = '{pcdtb_pkg::CFG_PACKET_RATE, pcdtb_pkg::CFG_BYTE_RATE,
            pcdtb_pkg::CFG_PACKET_BURST, pcdtb_pkg::CFG_BYTE_BURST,
            pcdtb_pkg::CFG_DECAY_IV, pcdtb_pkg::CFG_VIOL_LIMIT, pcdtb_pkg::CFG_QUAR_LEN};
    drain();
    repeat (60) @(posedge clk);
    foreach (idx[i]) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i][31:0];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    pkt_rate = vals[0] & 32'hFFFF_FFFF;
    byt_rate = vals[1] & 32'hFFFF_FFFF;
    pkt_burst = vals[2] & 16'hFFFF;
    byt_burst = vals[3] & 32'hFFFF_FFFF;
    decay_iv = vals[4] & 32'hFFFF_FFFF;
    viol_limit = vals[5] & 16'hFFFF;
    quar_len = vals[6] & 32'hFFFF_FFFF;
  endtask

  longint unsigned clock_ticks = 0;

  function automatic logic [47:0] next_tick();
    int pick;
    pick = $urandom_range(99);
    if (pick < 4 && clock_ticks > 64) return 48'(clock_ticks - $urandom_range(1, 60));
    if (pick < 30) clock_ticks += 0;
    else if (pick < 80) clock_ticks += $urandom_range(1, 20);
    else if (pick < 97) clock_ticks += $urandom_range(21, 2000);
    else clock_ticks += $urandom_range(2001, 10000000);
    if (clock_ticks > TMAX) clock_ticks = TMAX;
    return 48'(clock_ticks);
  endfunction

  function automatic logic [1:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 75) return pcdtb_pkg::OP_ALLOW;
    if (r < 83) return pcdtb_pkg::OP_RELEASE;
    if (r < 91) return pcdtb_pkg::OP_CLEAR;
    return pcdtb_pkg::OP_PEEK;
  endfunction

  function automatic logic [15:0] pick_bytes();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 16'($urandom_range(0, 1500));
    if (r < 60) return 16'hFFFF;
    if (r < 65) return 16'h0000;
    return 16'($urandom_range(0, 65535));
  endfunction

  initial begin
    verdict_t z;
    row_t rows [$];
    longint unsigned cfg [7];
    z = '0;
    pkt_rate = pcdtb_pkg::RST_PACKET_RATE;
    byt_rate = pcdtb_pkg::RST_BYTE_RATE;
    pkt_burst = pcdtb_pkg::RST_PACKET_BURST;
    byt_burst = pcdtb_pkg::RST_BYTE_BURST;
    decay_iv = pcdtb_pkg::RST_DECAY_IV;
    viol_limit = pcdtb_pkg::RST_VIOL_LIMIT;
    quar_len = pcdtb_pkg::RST_QUAR_LEN;
    foreach (used[i]) used[i] = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows = '{
      '{pcdtb_pkg::OP_ALLOW,   6'd0,  16'd0,     48'd0, 1'b1,
        '{1'b1, 1'b0, 16'd0, 16'd63, 32'd65536}},
      '{pcdtb_pkg::OP_ALLOW,   6'd0,  16'hFFFF,  48'd0, 1'b1,
        '{1'b1, 1'b0, 16'd0, 16'd62, 32'd1}},
      '{pcdtb_pkg::OP_ALLOW,   6'd0,  16'hFFFF,  48'd0, 1'b0, z},
      '{pcdtb_pkg::OP_PEEK,    6'd5,  16'd0,     48'd0, 1'b1, z},
      '{pcdtb_pkg::OP_CLEAR,   6'd5,  16'd0,     48'd0, 1'b1, z},
      '{pcdtb_pkg::OP_RELEASE, 6'd63, 16'd0,     48'd0, 1'b1, z},
      '{pcdtb_pkg::OP_PEEK,    6'd0,  16'd0,     48'd0, 1'b0, z},
      '{pcdtb_pkg::OP_ALLOW,   6'd0,  16'hFFFF,  48'd10, 1'b0, z},
      '{pcdtb_pkg::OP_CLEAR,   6'd0,  16'd0,     48'd10, 1'b0, z},
      '{pcdtb_pkg::OP_ALLOW,   6'd0,  16'd100,   48'd1000, 1'b0, z},
      '{pcdtb_pkg::OP_ALLOW,   6'd0,  16'd100,   48'd500, 1'b0, z},
      '{pcdtb_pkg::OP_ALLOW,   6'd63, 16'hFFFF,  48'hFFFF_FFFF_FFFF, 1'b1,
        '{1'b1, 1'b0, 16'd0, 16'd63, 32'd1}},
      '{pcdtb_pkg::OP_ALLOW,   6'd63, 16'h5555,  48'hFFFF_FFFF_FFFF, 1'b0, z},
      '{pcdtb_pkg::OP_PEEK,    6'd63, 16'hAAAA,  48'h8000_0000_0000, 1'b0, z},
      '{pcdtb_pkg::OP_RELEASE, 6'd0,  16'd0,     48'd2000, 1'b1, z},
      '{pcdtb_pkg::OP_PEEK,    6'd0,  16'd0,     48'd2000, 1'b1, z},
      '{pcdtb_pkg::OP_ALLOW,   6'd0,  16'd1,     48'd2000, 1'b1,
        '{1'b1, 1'b0, 16'd0, 16'd63, 32'd65535}}
    };
    foreach (rows[i]) send(rows[i].op, rows[i].slot, rows[i].bytes, rows[i].now,
                           rows[i].typed, rows[i].want);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: cfg = '{1, 1, 4, 3000, 50, 3, 200};
        1: cfg = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF};
        2: cfg = '{32'h8000, 32'h8000, 1, 1, 1, 1, 0};
        3: cfg = '{32'h4000, 32'h20000, 2, 800, 7, 1, 32'hFFFF_FFFF};
        default: cfg = '{$urandom_range(1, 32'h40000), $urandom_range(1, 32'h400000),
                         $urandom_range(1, 16), $urandom_range(100, 200000),
                         $urandom_range(1, 500), $urandom_range(1, 8),
                         $urandom_range(0, 2000)};
      endcase
      write_regs(cfg);
      calm = (phase == 1);
      if (phase == 3) clock_ticks = TMAX - 20000;
      if (phase == 4) clock_ticks = 0;
      for (int n = 0; n < 92; n++) begin
        if (n == 46 && phase == 5) drain();
        send(pick_op(),
             6'(($urandom_range(3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 5)),
             pick_bytes(), next_tick());
      end
    end
    calm = 1'b0;
    drain();
    repeat (60) @(posedge clk);

    $display("%0d items sent over 8 register settings: %0d passed, %0d rejected, %0d quarantined",
             items_in, passes, rejects, quar_seen);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
